>>> hdl/dgrx_pkg.sv
package dgrx_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned SrcRange  = 2 ** ByteW;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 56;

  localparam logic [ByteW-1:0] HDR_BYTES = 8'd4;

  localparam logic [CfgIndexW-1:0] REG_OWN_ADDR  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_PROMISC   = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_BCAST     = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_WILDCARD  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_ACK_MASK  = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_MAX_LEN   = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] own_address;
    logic             promiscuous;
    logic [ByteW-1:0] broadcast_address;
    logic [ByteW-1:0] wildcard_address;
    logic [ByteW-1:0] ack_flag_mask;
    logic [ByteW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_flags;
    logic [ByteW-1:0] seq_id;
    logic [ByteW-1:0] source;
    logic [ByteW-1:0] dest;
    logic [ByteW-1:0] frame_len;
  } hdr_t;

endpackage

>>> hdl/datagram_rx_ack_dedup_filter.sv
// Receive header filter for a reliable datagram link. Each input transaction
// carries one frame header; each output transaction carries its verdict
// (accepted, deliver_new, send_ack, ack_seen), the source, dest, seq and flags
// bytes (zero unless accepted) and the running good-frame count. For each
// frame the block first reads the last-seen id of its source from the id
// memory, which has a registered read, then compares, writes a fresh id back and
// loads the output register. The next header is taken in the cycle after that
// load, so frames are handled one at a time; if the output register is still
// occupied, the compare step waits for it. The id table is empty right after
// reset, with no clearing pass. Configuration writes are taken at any time but
// must only be issued while no frame is in progress.
module datagram_rx_ack_dedup_filter
  import dgrx_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // frame_len[7:0], dest[15:8], source[23:16], seq_id[31:24], frame_flags[39:32]
  input  logic [InDataW-1:0]   in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // accepted[0], deliver_new[1], send_ack[2], ack_seen[3], msg_source[11:4],
  // msg_dest[19:12], msg_seq[27:20], msg_flags[35:28], good_count[51:36]
  output logic [OutDataW-1:0]  out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ByteW-1:0]     cfg_data
);

  localparam int unsigned AddrW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  cfg_t   cfg;
  hdr_t   in_hdr;
  hdr_t   hdr_r;
  state_t state_r;

  logic [AddrW-1:0]  slot_lut [SrcRange];
  logic [AddrW-1:0]  slot_r;
  logic [ByteW-1:0]  last_id;
  logic              in_xfer;
  logic              out_free;
  logic              load;
  logic              len_ok;
  logic              addr_ok;
  logic              acc;
  logic              is_ack;
  logic              ack_req;
  logic              fresh;
  logic [CountW-1:0] good_frames_r;
  logic [CountW-1:0] good_nxt;

  logic              out_tvalid_r;
  logic              out_accepted_r;
  logic              out_deliver_r;
  logic              out_send_ack_r;
  logic              out_ack_seen_r;
  logic [ByteW-1:0]  out_source_r;
  logic [ByteW-1:0]  out_dest_r;
  logic [ByteW-1:0]  out_seq_r;
  logic [ByteW-1:0]  out_flags_r;
  logic [CountW-1:0] out_count_r;

  for (genvar gi = 0; gi < SrcRange; gi++) begin : g_slot
    localparam int unsigned SlotVal = gi % NODE_COUNT;
    assign slot_lut[gi] = AddrW'(SlotVal);
  end

  dgrx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_hdr    = hdr_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign load      = (state_r == ST_LOOKUP) && out_free;

  dgrx_id_mem #(
    .Depth (NODE_COUNT),
    .AddrW (AddrW)
  ) u_id_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (slot_lut[in_hdr.source]),
    .rd_data (last_id),
    .wr_en   (load && fresh),
    .wr_addr (slot_r),
    .wr_data (hdr_r.seq_id)
  );

  always_comb begin
    len_ok  = (hdr_r.frame_len >= HDR_BYTES) && (hdr_r.frame_len <= cfg.max_frame_len);
    addr_ok = cfg.promiscuous || (hdr_r.dest == cfg.own_address) ||
              (hdr_r.dest == cfg.broadcast_address) ||
              (hdr_r.dest == cfg.wildcard_address);
    acc     = len_ok && addr_ok;
    is_ack  = |(hdr_r.frame_flags & cfg.ack_flag_mask);
    ack_req = acc && !is_ack &&
              ((hdr_r.dest == cfg.own_address) || (hdr_r.dest == cfg.wildcard_address));
    fresh   = acc && !is_ack && (last_id != hdr_r.seq_id);
    good_nxt = acc ? good_frames_r + 16'd1 : good_frames_r;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr_r  <= in_hdr;
      slot_r <= slot_lut[in_hdr.source];
    end
    if (load) begin
      out_accepted_r <= acc;
      out_deliver_r  <= fresh;
      out_send_ack_r <= ack_req;
      out_ack_seen_r <= acc && is_ack;
      out_source_r   <= acc ? hdr_r.source : '0;
      out_dest_r     <= acc ? hdr_r.dest : '0;
      out_seq_r      <= acc ? hdr_r.seq_id : '0;
      out_flags_r    <= acc ? hdr_r.frame_flags : '0;
      out_count_r    <= good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_tvalid_r  <= 1'b0;
      good_frames_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_LOOKUP;
          end
          if (out_tvalid_r && out_tready) begin
            out_tvalid_r <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          if (load) begin
            state_r       <= ST_IDLE;
            out_tvalid_r  <= 1'b1;
            good_frames_r <= good_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_count_r, out_flags_r, out_seq_r, out_dest_r,
                       out_source_r, out_ack_seen_r, out_send_ack_r,
                       out_deliver_r, out_accepted_r};

  a_deliver_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (!out_deliver_r || out_accepted_r))
    else $error("deliver_new without accepted");

  a_ack_req_not_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (!out_send_ack_r || (out_accepted_r && !out_ack_seen_r)))
    else $error("send_ack on rejected or ACK frame");

  a_one_frame_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("header taken while lookup pending");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load && acc) |=> (good_frames_r == CountW'($past(good_frames_r) + 16'd1)))
    else $error("good-frame count did not advance");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && acc) |=> $stable(good_frames_r))
    else $error("good-frame count changed without accepted frame");

endmodule

>>> hdl/dgrx_cfg_regs.sv
module dgrx_cfg_regs
  import dgrx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ByteW-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address       <= 8'd255;
      cfg_r.promiscuous       <= 1'b0;
      cfg_r.broadcast_address <= 8'd255;
      cfg_r.wildcard_address  <= 8'd0;
      cfg_r.ack_flag_mask     <= 8'd128;
      cfg_r.max_frame_len     <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDR: cfg_r.own_address       <= cfg_data;
        REG_PROMISC:  cfg_r.promiscuous       <= cfg_data[0];
        REG_BCAST:    cfg_r.broadcast_address <= cfg_data;
        REG_WILDCARD: cfg_r.wildcard_address  <= cfg_data;
        REG_ACK_MASK: cfg_r.ack_flag_mask     <= cfg_data;
        REG_MAX_LEN:  cfg_r.max_frame_len     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/dgrx_id_mem.sv
module dgrx_id_mem
  import dgrx_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [ByteW-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [ByteW-1:0] wr_data
);

  logic [ByteW-1:0] mem [Depth];
  logic [Depth-1:0] vld_r;
  logic [ByteW-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> dv/dgrx_verdict_checker.sv
`timescale 1ns / 1ps

module dgrx_verdict_checker
  import dgrx_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [InDataW-1:0]   in_tdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [OutDataW-1:0]  out_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ByteW-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pending_results
);

  typedef struct packed {
    logic [OutDataW-CountW-4*ByteW-5:0] spare;
    logic [CountW-1:0]                  good_count;
    logic [ByteW-1:0]                   msg_flags;
    logic [ByteW-1:0]                   msg_seq;
    logic [ByteW-1:0]                   msg_dest;
    logic [ByteW-1:0]                   msg_source;
    logic                               ack_seen;
    logic                               send_ack;
    logic                               deliver_new;
    logic                               accepted;
  } verdict_t;

  cfg_t              regs;
  logic [ByteW-1:0]  last_seen_seq [NODE_COUNT];
  logic [CountW-1:0] good_frames;
  verdict_t          verdicts_due [$];

  function automatic verdict_t screen_frame(hdr_t h);
    verdict_t v;
    logic     len_ok;
    logic     addr_ok;
    logic     is_ack;
    int       slot;
    v       = '0;
    len_ok  = (h.frame_len >= HDR_BYTES) && (h.frame_len <= regs.max_frame_len);
    addr_ok = regs.promiscuous || (h.dest == regs.own_address) ||
              (h.dest == regs.broadcast_address) || (h.dest == regs.wildcard_address);
    is_ack  = (h.frame_flags & regs.ack_flag_mask) != '0;
    if (len_ok && addr_ok) begin
      good_frames  = good_frames + 1'b1;
      v.accepted   = 1'b1;
      v.ack_seen   = is_ack;
      v.msg_source = h.source;
      v.msg_dest   = h.dest;
      v.msg_seq    = h.seq_id;
      v.msg_flags  = h.frame_flags;
      if (!is_ack) begin
        v.send_ack = (h.dest == regs.own_address) || (h.dest == regs.wildcard_address);
        slot = int'(h.source) % NODE_COUNT;
        if (last_seen_seq[slot] != h.seq_id) begin
          v.deliver_new       = 1'b1;
          last_seen_seq[slot] = h.seq_id;
        end
      end
    end
    v.good_count = good_frames;
    return v;
  endfunction

  task automatic load_register(logic [CfgIndexW-1:0] idx, logic [ByteW-1:0] val);
    case (idx)
      REG_OWN_ADDR: regs.own_address       = val;
      REG_PROMISC:  regs.promiscuous       = val[0];
      REG_BCAST:    regs.broadcast_address = val;
      REG_WILDCARD: regs.wildcard_address  = val;
      REG_ACK_MASK: regs.ack_flag_mask     = val;
      REG_MAX_LEN:  regs.max_frame_len     = val;
      default: ;
    endcase
  endtask

  task automatic check_verdict(verdict_t got);
    verdict_t exp;
    if (verdicts_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected output transaction %h", $realtime, got);
    end else begin
      exp = verdicts_due.pop_front();
      if (got.accepted !== exp.accepted || got.deliver_new !== exp.deliver_new ||
          got.send_ack !== exp.send_ack || got.ack_seen !== exp.ack_seen ||
          got.msg_source !== exp.msg_source || got.msg_dest !== exp.msg_dest ||
          got.msg_seq !== exp.msg_seq || got.msg_flags !== exp.msg_flags ||
          got.good_count !== exp.good_count || got.spare !== exp.spare) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: verdict mismatch", $realtime);
          $display("  exp acc=%b new=%b ack=%b seen=%b src=%h dst=%h seq=%h flg=%h cnt=%0d pad=%h",
                   exp.accepted, exp.deliver_new, exp.send_ack, exp.ack_seen, exp.msg_source,
                   exp.msg_dest, exp.msg_seq, exp.msg_flags, exp.good_count, exp.spare);
          $display("  got acc=%b new=%b ack=%b seen=%b src=%h dst=%h seq=%h flg=%h cnt=%0d pad=%h",
                   got.accepted, got.deliver_new, got.send_ack, got.ack_seen, got.msg_source,
                   got.msg_dest, got.msg_seq, got.msg_flags, got.good_count, got.spare);
        end
      end
    end
  endtask

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.own_address       = 8'd255;
      regs.promiscuous       = 1'b0;
      regs.broadcast_address = 8'd255;
      regs.wildcard_address  = 8'd0;
      regs.ack_flag_mask     = 8'd128;
      regs.max_frame_len     = 8'd64;
      foreach (last_seen_seq[i]) last_seen_seq[i] = '0;
      good_frames = '0;
      verdicts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      // retire the output first so a result never meets its own frame
      if (out_tvalid && out_tready) check_verdict(verdict_t'(out_tdata));
      if (in_tvalid && in_tready) verdicts_due.push_back(screen_frame(hdr_t'(in_tdata)));
    end
    pending_results = verdicts_due.size();
  end

endmodule

>>> dv/tb_datagram_rx_ack_dedup_filter.sv
`timescale 1ns / 1ps

module tb_datagram_rx_ack_dedup_filter;
  import dgrx_pkg::*;

  localparam int unsigned NODES      = 256;
  localparam int          STALL_MAX  = 5000;
  localparam logic [CfgIndexW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_UNMAPPED_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [InDataW-1:0]   in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OutDataW-1:0]  out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [ByteW-1:0]     cfg_data = '0;

  int   mismatch_count;
  int   pending_results;
  int   send_idle_pct = 33;
  int   recv_idle_pct = 47;
  int   stall_cycles = 0;
  cfg_t live_cfg;

  datagram_rx_ack_dedup_filter #(.NODE_COUNT(NODES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dgrx_verdict_checker #(.NODE_COUNT(NODES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("tb_datagram_rx_ack_dedup_filter: errors");
      $finish;
    end
  end

  function automatic hdr_t hdr(logic [7:0] len, logic [7:0] dst, logic [7:0] src,
                               logic [7:0] seq, logic [7:0] flg);
    hdr_t h;
    h.frame_len   = len;
    h.dest        = dst;
    h.source      = src;
    h.seq_id      = seq;
    h.frame_flags = flg;
    return h;
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  // well-formed frames mostly hit the configured addresses, sources 0 to 7,
  // ids 0 to 3 and non-ACK flags, so duplicates show up often
  function automatic hdr_t make_frame(bit tidy);
    hdr_t h;
    h = hdr(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
            ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
            ByteW'($urandom_range(255)));
    if (tidy) begin
      if (live_cfg.max_frame_len >= HDR_BYTES)
        h.frame_len = ByteW'($urandom_range(live_cfg.max_frame_len, HDR_BYTES));
      case ($urandom_range(3))
        0: h.dest = live_cfg.own_address;
        1: h.dest = live_cfg.broadcast_address;
        2: h.dest = live_cfg.wildcard_address;
        default: ;
      endcase
      if ($urandom_range(3) != 0) h.source = ByteW'($urandom_range(7));
      if ($urandom_range(3) != 0) h.seq_id = ByteW'($urandom_range(3));
      if ($urandom_range(3) != 0) h.frame_flags = h.frame_flags & ~live_cfg.ack_flag_mask;
    end
    return h;
  endfunction

  task automatic push_frame(hdr_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= h;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_settled();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic set_reg(logic [CfgIndexW-1:0] idx, logic [ByteW-1:0] val);
    case (idx)
      REG_OWN_ADDR: live_cfg.own_address       = val;
      REG_PROMISC:  live_cfg.promiscuous       = val[0];
      REG_BCAST:    live_cfg.broadcast_address = val;
      REG_WILDCARD: live_cfg.wildcard_address  = val;
      REG_ACK_MASK: live_cfg.ack_flag_mask     = val;
      REG_MAX_LEN:  live_cfg.max_frame_len     = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [ByteW-1:0] mask;
    logic [ByteW-1:0] maxlen;
    case ($urandom_range(3))
      0:       mask = 8'h00;
      1:       mask = 8'hFF;
      2:       mask = 8'h01 << $urandom_range(7);
      default: mask = ByteW'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0:       maxlen = HDR_BYTES;
      1, 2:    maxlen = 8'd255;
      3:       maxlen = ByteW'($urandom_range(3));
      default: maxlen = ByteW'($urandom_range(255, 4));
    endcase
    set_reg(REG_OWN_ADDR, pick_byte());
    set_reg(REG_PROMISC, ByteW'($urandom_range(255)));
    set_reg(REG_BCAST, pick_byte());
    set_reg(REG_WILDCARD, pick_byte());
    set_reg(REG_ACK_MASK, mask);
    set_reg(REG_MAX_LEN, maxlen);
    if ($urandom_range(3) == 0) set_reg(CfgIndexW'($urandom_range(7, 6)), pick_byte());
  endtask

  initial begin
    live_cfg.own_address       = 8'd255;
    live_cfg.promiscuous       = 1'b0;
    live_cfg.broadcast_address = 8'd255;
    live_cfg.wildcard_address  = 8'd0;
    live_cfg.ack_flag_mask     = 8'd128;
    live_cfg.max_frame_len     = 8'd64;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: length bounds, first id zero, ACK frames, foreign dest
    push_frame(hdr(8'd3, 8'hFF, 8'h01, 8'h11, 8'h00));
    push_frame(hdr(8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    push_frame(hdr(8'd4, 8'hFF, 8'h01, 8'h00, 8'h00));
    push_frame(hdr(8'd64, 8'h00, 8'h01, 8'h07, 8'h7F));
    push_frame(hdr(8'd65, 8'h00, 8'h02, 8'h07, 8'h00));
    push_frame(hdr(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_frame(hdr(8'd64, 8'h00, 8'h01, 8'h07, 8'h00));
    push_frame(hdr(8'd10, 8'h00, 8'h01, 8'h09, 8'h80));
    push_frame(hdr(8'd10, 8'h00, 8'h01, 8'h09, 8'h00));
    push_frame(hdr(8'd20, 8'h42, 8'h03, 8'h05, 8'h00));
    wait_results_settled();

    set_reg(REG_OWN_ADDR, 8'h5A);
    set_reg(REG_PROMISC, 8'h01);
    set_reg(REG_BCAST, 8'hA5);
    set_reg(REG_WILDCARD, 8'h3C);
    set_reg(REG_ACK_MASK, 8'h00);
    set_reg(REG_MAX_LEN, 8'd255);
    set_reg(REG_UNMAPPED_LO, 8'hFF);
    set_reg(REG_UNMAPPED_HI, 8'h00);
    push_frame(hdr(8'd255, 8'h42, 8'h80, 8'h01, 8'hFF));
    push_frame(hdr(8'd30, 8'hA5, 8'h80, 8'h02, 8'h00));
    push_frame(hdr(8'd30, 8'h5A, 8'h80, 8'h02, 8'h00));
    push_frame(hdr(8'd30, 8'h3C, 8'hFF, 8'hFF, 8'h00));
    wait_results_settled();

    set_reg(REG_MAX_LEN, 8'd3);
    push_frame(hdr(8'd3, 8'h5A, 8'h04, 8'h01, 8'h00));
    push_frame(hdr(8'd4, 8'h5A, 8'h04, 8'h01, 8'h00));
    wait_results_settled();
    set_reg(REG_MAX_LEN, 8'd4);
    set_reg(REG_ACK_MASK, 8'hFF);
    push_frame(hdr(8'd4, 8'h5A, 8'h05, 8'h01, 8'h01));
    push_frame(hdr(8'd5, 8'h5A, 8'h05, 8'h01, 8'h00));
    push_frame(hdr(8'd4, 8'h5A, 8'h05, 8'h01, 8'h00));
    wait_results_settled();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 33 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        wait_results_settled();
        pick_settings();
        repeat (42) push_frame(make_frame($urandom_range(9) < 8));
      end
    end

    wait_results_settled();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_datagram_rx_ack_dedup_filter: clean");
    end else begin
      $display("tb_datagram_rx_ack_dedup_filter: errors");
    end
    $finish;
  end

endmodule
